// File: rtl/msi_vector_bitmap_allocator_assert.svh
// assertion macros for the msi vector bitmap allocator
`ifndef MSI_VECTOR_BITMAP_ALLOCATOR_ASSERT_SVH
`define MSI_VECTOR_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSIVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msiva assertion failed");

// next-cycle implication, checked outside reset
`define MSIVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msiva assertion failed");

`endif

// File: rtl/msiva_pkg.sv
// shared constants and types of the msi vector bitmap allocator
`default_nettype none

package msiva_pkg;

    // bits per word of the used-bit memory
    localparam int WORD_W = 32;
    localparam int WORD_SHIFT = 5;

    // vector numbers are 8 bits wide
    localparam int ADDR_SPAN = 256;
    localparam int VEC_W = 8;
    localparam int COUNT_W = 9;

    // parameter defaults
    localparam int DEF_VECTORS = 256;
    localparam int DEF_RESERVED = 16;

    // reset value of the vector count register
    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 9'd256;

    // request kind
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

`default_nettype wire

// File: rtl/msi_vector_bitmap_allocator.sv
// first-fit interrupt vector allocator over a used-bit map held in a word memory
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_ready  i_mode, i_vector
//   result    out        o_valid / i_ready  o_granted, o_status
//   config    in         i_cfg_we           i_cfg_data (vector count)
//
// the map lives in a 32-bit-wide memory, one word read per cycle (registered read).
// allocate: scans words until one has a free bit (1 to 8 words for 256 vectors).
// release: one read-modify-write when in range, none otherwise.
// after reset a clearing pass writes every word (ceil(min(VECTORS,256)/32) words, 8
// by default) before the first request is taken; a result waiting on i_ready does
// not block the next request, only the handoff of the one after it.
`default_nettype none

module msi_vector_bitmap_allocator #(
    parameter int VECTORS  = msiva_pkg::DEF_VECTORS,
    parameter int RESERVED = msiva_pkg::DEF_RESERVED
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_mode,
    input  wire logic [msiva_pkg::VEC_W-1:0]     i_vector,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [msiva_pkg::VEC_W-1:0]          o_granted,
    output logic [1:0]                           o_status,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [msiva_pkg::COUNT_W-1:0]   i_cfg_data
);

    // only vectors below 256 can ever be searched or released
    localparam int SPAN  = (VECTORS < msiva_pkg::ADDR_SPAN) ? VECTORS : msiva_pkg::ADDR_SPAN;
    localparam int WORDS = (SPAN + msiva_pkg::WORD_W - 1) / msiva_pkg::WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = msiva_pkg::WORD_SHIFT;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_REL,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [WAW-1:0]                  r_addr;
    logic [BW-1:0]                   r_bit;
    logic [msiva_pkg::WORD_W-1:0]    r_rdata;
    logic [msiva_pkg::WORD_W-1:0]    mem [WORDS];
    logic [msiva_pkg::COUNT_W-1:0]   r_vector_count;
    logic [msiva_pkg::VEC_W-1:0]     r_res_granted;
    msiva_pkg::t_status              r_res_status;
    logic                            r_o_valid;
    logic [msiva_pkg::VEC_W-1:0]     r_o_granted;
    msiva_pkg::t_status              r_o_status;

    logic [msiva_pkg::COUNT_W-1:0]   s_n;
    logic [msiva_pkg::COUNT_W-1:0]   s_base;
    logic [msiva_pkg::COUNT_W:0]     s_next_base;
    logic [msiva_pkg::WORD_W-1:0]    s_mask;
    logic [msiva_pkg::WORD_W-1:0]    s_free;
    logic [msiva_pkg::WORD_W-1:0]    s_init_word;
    logic [BW-1:0]                   s_idx;
    logic [2:0]                      s_vec_word;
    logic                            s_accept;
    logic                            s_rel_bad;
    logic                            s_we;
    logic [WAW-1:0]                  s_waddr;
    logic [msiva_pkg::WORD_W-1:0]    s_wdata;
    logic [WAW-1:0]                  s_raddr;

    assign s_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_granted = r_o_granted;
    assign o_status  = r_o_status;

    // usable count: smaller of the register and the stored span
    assign s_n = (r_vector_count > msiva_pkg::COUNT_W'(SPAN))
               ? msiva_pkg::COUNT_W'(SPAN) : r_vector_count;

    // first vector number of the word under scan
    assign s_base      = msiva_pkg::COUNT_W'({r_addr, {BW{1'b0}}});
    assign s_next_base = {1'b0, s_base} + (msiva_pkg::COUNT_W + 1)'(msiva_pkg::WORD_W);

    // word index of a released vector
    assign s_vec_word = i_vector[msiva_pkg::VEC_W-1:BW];

    assign s_rel_bad = ({1'b0, i_vector} < msiva_pkg::COUNT_W'(RESERVED))
                    || ({1'b0, i_vector} >= s_n);

    // per-bit range mask, free bits and reserved pattern of the current word
    always_comb begin
        for (int b = 0; b < msiva_pkg::WORD_W; b++) begin
            s_mask[b]      = ((s_base + msiva_pkg::COUNT_W'(b)) < s_n);
            s_init_word[b] = ((int'(r_addr) * msiva_pkg::WORD_W + b) < RESERVED);
        end
        s_free = ~r_rdata & s_mask;
    end

    // lowest free bit of the word
    always_comb begin
        s_idx = '0;
        for (int b = msiva_pkg::WORD_W - 1; b >= 0; b--) begin
            if (s_free[b]) begin
                s_idx = BW'(b);
            end
        end
    end

    // memory write and read address selection
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_addr;
        s_wdata = r_rdata;
        s_raddr = '0;
        case (r_state)
            S_INIT: begin
                s_we    = 1'b1;
                s_wdata = s_init_word;
            end
            S_IDLE: begin
                if (i_mode == msiva_pkg::MODE_RELEASE) begin
                    s_raddr = WAW'(s_vec_word);
                end
            end
            S_SCAN: begin
                if (s_free != '0) begin
                    s_we    = 1'b1;
                    s_wdata = r_rdata | (msiva_pkg::WORD_W'(1) << s_idx);
                end else begin
                    s_raddr = r_addr + WAW'(1);
                end
            end
            S_REL: begin
                s_we    = 1'b1;
                s_wdata = r_rdata & ~(msiva_pkg::WORD_W'(1) << r_bit);
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    // used-bit memory
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem[s_waddr] <= s_wdata;
        end
        r_rdata <= mem[s_raddr];
    end

    // vector count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_count <= msiva_pkg::VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vector_count <= i_cfg_data;
        end
    end

    // control sequencer and output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_addr    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // output word taken and no new word loaded behind it
            if (r_o_valid && i_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (r_addr == WAW'(WORDS - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + WAW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_bit <= i_vector[BW-1:0];
                        r_res_granted <= '0;
                        if (i_mode == msiva_pkg::MODE_ALLOC) begin
                            r_addr  <= '0;
                            r_state <= S_SCAN;
                        end else if (s_rel_bad) begin
                            r_res_status <= msiva_pkg::ST_RANGE;
                            r_state      <= S_OUT;
                        end else begin
                            r_addr  <= WAW'(s_vec_word);
                            r_state <= S_REL;
                        end
                    end
                end
                S_SCAN: begin
                    if (s_free != '0) begin
                        r_res_granted <= msiva_pkg::VEC_W'({r_addr, s_idx});
                        r_res_status  <= msiva_pkg::ST_OK;
                        r_state       <= S_OUT;
                    end else if (s_next_base >= {1'b0, s_n}) begin
                        r_res_status <= msiva_pkg::ST_FULL;
                        r_state      <= S_OUT;
                    end else begin
                        r_addr <= r_addr + WAW'(1);
                    end
                end
                S_REL: begin
                    r_res_status <= msiva_pkg::ST_OK;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_granted <= r_res_granted;
                        r_o_status  <= r_res_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `include "msi_vector_bitmap_allocator_assert.svh"

    // an accepted request always takes the sequencer out of idle in the next cycle
    `MSIVA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_accept, r_state != S_IDLE)
    // no request is taken during the clearing pass
    `MSIVA_ASSERT_NOW(a_init_closed, i_clk, i_rst_n, r_state == S_INIT, !o_ready)
    // status is one of the three defined codes
    `MSIVA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_valid, (o_status == msiva_pkg::ST_OK || o_status == msiva_pkg::ST_FULL || o_status == msiva_pkg::ST_RANGE))
    // a failed or flagged result never carries a vector number
    `MSIVA_ASSERT_NOW(a_granted_zero, i_clk, i_rst_n, o_valid && (o_status != msiva_pkg::ST_OK), o_granted == '0)

endmodule

`default_nettype wire
